>>> hw/rtl/lmcd_pkg.sv
// shared types, constants and microcode rom for the led matrix chain driver
`timescale 1ns / 1ps

package lmcd_pkg;

    // chain geometry
    localparam int NUM_BLOCKS     = 4;
    localparam int ROWS_PER_BLOCK = 8;
    localparam int SHADOW_DEPTH   = 32;
    localparam int FRAME_W        = 64;

    localparam logic [2:0] NUM_BLOCKS_W = 3'(NUM_BLOCKS);
    localparam logic [2:0] LAST_ROW     = 3'(ROWS_PER_BLOCK - 1);
    localparam logic [7:0] COL0_MASK    = 8'b1000_0000;
    localparam logic [7:0] ROW_ADDR_INC = 8'h01;

    // command codes
    localparam logic [1:0] OP_RAW = 2'd0;
    localparam logic [1:0] OP_LED = 2'd1;
    localparam logic [1:0] OP_COL = 2'd2;
    localparam logic [1:0] OP_CLR = 2'd3;

    // microcode addresses
    localparam logic [2:0] UA_DISPATCH = 3'd0;
    localparam logic [2:0] UA_RAW      = 3'd1;
    localparam logic [2:0] UA_LED      = 3'd2;
    localparam logic [2:0] UA_COL      = 3'd3;
    localparam logic [2:0] UA_CLR      = 3'd4;

    // frame source for an emitting step
    typedef enum logic [1:0] {
        FRM_RAW  = 2'd0,
        FRM_LED  = 2'd1,
        FRM_ZERO = 2'd2
    } frm_sel_t;

    typedef enum logic {
        ROW_IN  = 1'b0,
        ROW_CNT = 1'b1
    } row_sel_t;

    typedef enum logic {
        BIT_ON  = 1'b0,
        BIT_PAT = 1'b1
    } bit_sel_t;

    // sequencing of the next step
    typedef enum logic [1:0] {
        NXT_DISPATCH = 2'd0,
        NXT_END      = 2'd1,
        NXT_LOOP     = 2'd2
    } nxt_t;

    typedef struct packed {
        frm_sel_t frm;
        row_sel_t row_sel;
        bit_sel_t bit_sel;
        logic     emit;
        nxt_t     nxt;
    } uword_t;

    // sequencer to datapath control
    typedef struct packed {
        logic       fire;
        frm_sel_t   frm;
        logic [1:0] blk;
        logic [2:0] row;
        logic [2:0] col;
        logic       bit_val;
        logic       last;
        logic [3:0] reg_addr;
        logic [7:0] data;
    } dp_ctl_t;

    // control store
    function automatic uword_t ucode_rom(input logic [2:0] upc);
        uword_t uw;
        unique case (upc)
            UA_DISPATCH: uw = '{FRM_RAW,  ROW_IN,  BIT_ON,  1'b0, NXT_DISPATCH};
            UA_RAW:      uw = '{FRM_RAW,  ROW_IN,  BIT_ON,  1'b1, NXT_END};
            UA_LED:      uw = '{FRM_LED,  ROW_IN,  BIT_ON,  1'b1, NXT_END};
            UA_COL:      uw = '{FRM_LED,  ROW_CNT, BIT_PAT, 1'b1, NXT_LOOP};
            UA_CLR:      uw = '{FRM_ZERO, ROW_CNT, BIT_ON,  1'b1, NXT_LOOP};
            default:     uw = '{FRM_RAW,  ROW_IN,  BIT_ON,  1'b0, NXT_END};
        endcase
        return uw;
    endfunction

endpackage

>>> hw/rtl/lmcd_sequencer.sv
// microcode sequencer: command latch, micro pc, row counter and jumps
`timescale 1ns / 1ps

module lmcd_sequencer
    import lmcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [1:0] s_block,
    input  logic [2:0] s_row,
    input  logic [2:0] s_column,
    input  logic       s_led_on,
    input  logic [7:0] s_data,
    input  logic [3:0] s_reg_addr,
    input  logic       out_free,
    output dp_ctl_t    ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] upc_reg, upc_next;
    logic [2:0] cnt_reg, cnt_next;

    logic [1:0] op_reg;
    logic [1:0] blk_reg;
    logic [2:0] row_reg;
    logic [2:0] col_reg;
    logic       on_reg;
    logic [7:0] data_reg;
    logic [3:0] addr_reg;

    uword_t     uw;
    logic       accept;
    logic       step_go;
    logic       blk_bad;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign uw      = ucode_rom(upc_reg);
    assign blk_bad = ({1'b0, blk_reg} >= NUM_BLOCKS_W);
    assign step_go = (state_reg == ST_RUN) && (!uw.emit || out_free);

    // control word to the datapath
    always_comb begin
        ctl          = '0;
        ctl.fire     = step_go && uw.emit;
        ctl.frm      = uw.frm;
        ctl.blk      = blk_reg;
        ctl.row      = (uw.row_sel == ROW_CNT) ? cnt_reg : row_reg;
        ctl.col      = col_reg;
        ctl.bit_val  = (uw.bit_sel == BIT_PAT) ? data_reg[~cnt_reg] : on_reg;
        ctl.last     = (uw.nxt == NXT_END) || (cnt_reg == LAST_ROW);
        ctl.reg_addr = addr_reg;
        ctl.data     = data_reg;
    end

    // next micro pc, counter and state
    always_comb begin
        state_next = state_reg;
        upc_next   = upc_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                    upc_next   = UA_DISPATCH;
                    cnt_next   = '0;
                end
            end
            ST_RUN: begin
                if (step_go) begin
                    unique case (uw.nxt)
                        NXT_DISPATCH: begin
                            if (blk_bad) begin
                                state_next = ST_IDLE;
                            end else begin
                                upc_next = UA_RAW + {1'b0, op_reg};
                            end
                        end
                        NXT_LOOP: begin
                            if (cnt_reg == LAST_ROW) begin
                                state_next = ST_IDLE;
                            end else begin
                                cnt_next = cnt_reg + 3'd1;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            upc_reg   <= UA_DISPATCH;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
            cnt_reg   <= cnt_next;
        end
    end

    // command latch
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_op;
            blk_reg  <= s_block;
            row_reg  <= s_row;
            col_reg  <= s_column;
            on_reg   <= s_led_on;
            data_reg <= s_data;
            addr_reg <= s_reg_addr;
        end
    end

endmodule

>>> hw/rtl/lmcd_datapath.sv
// shadow row store, frame builder and output register
`timescale 1ns / 1ps

module lmcd_datapath
    import lmcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_ctl_t            ctl,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FRAME_W-1:0] m_chain_word,
    output logic               m_last
);

    logic [7:0]         shadow_reg [SHADOW_DEPTH];
    logic [4:0]         idx;
    logic [7:0]         cur_row;
    logic [7:0]         mask;
    logic [7:0]         led_row;
    logic [7:0]         frm_addr;
    logic [7:0]         frm_val;
    logic [FRAME_W-1:0] frame;

    logic               m_valid_reg;
    logic [FRAME_W-1:0] chain_reg;
    logic               last_reg;

    assign idx      = {ctl.blk, ctl.row};
    assign cur_row  = shadow_reg[idx];
    assign mask     = COL0_MASK >> ctl.col;
    assign led_row  = ctl.bit_val ? (cur_row | mask) : (cur_row & ~mask);
    assign out_free = !m_valid_reg || m_ready;

    // register address and data byte for the target block
    always_comb begin
        unique case (ctl.frm)
            FRM_RAW: begin
                frm_addr = {4'b0, ctl.reg_addr};
                frm_val  = ctl.data;
            end
            FRM_LED: begin
                frm_addr = {5'b0, ctl.row} + ROW_ADDR_INC;
                frm_val  = led_row;
            end
            FRM_ZERO: begin
                frm_addr = {5'b0, ctl.row} + ROW_ADDR_INC;
                frm_val  = '0;
            end
            default: begin
                frm_addr = '0;
                frm_val  = '0;
            end
        endcase
    end

    // place the pair in the target block's slot, no-ops elsewhere
    assign frame = {48'b0, frm_addr, frm_val} << {ctl.blk, 4'b0};

    // shadow rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SHADOW_DEPTH; i++) begin
                shadow_reg[i] <= '0;
            end
        end else if (ctl.fire) begin
            if (ctl.frm == FRM_LED) begin
                shadow_reg[idx] <= led_row;
            end else if (ctl.frm == FRM_ZERO) begin
                shadow_reg[idx] <= '0;
            end
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fire) begin
            chain_reg <= frame;
            last_reg  <= ctl.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chain_word = chain_reg;
    assign m_last       = last_reg;

endmodule

>>> hw/rtl/led_matrix_chain_driver_unit.sv
// top level of the led matrix chain driver
`timescale 1ns / 1ps
// Command front end for a daisy chain of 8x8 LED matrix driver chips.
// Input channel (s_*): one command per beat: raw register write, set one
// LED, set a column from a pattern, or clear a block. Commands that name a
// block beyond the chain are dropped without output.
// Output channel (m_*): one 64-bit chain frame per beat, block b in bits
// 16b+15..16b, no-op zeros for the other blocks; m_last marks the final
// frame of a command. A downstream shifter sends each frame MSB first.
// The command beat is latched, a dispatch microstep selects the command's
// microroutine, and each emitting microstep loads one frame into the
// single output register. One command is worked at a time. The sequencer
// issues at most one frame per cycle into that register, and fewer when
// the receiver stalls it.
// When the receiver stalls, the emitting microstep waits and the frame in
// the output register holds; s_ready stays low until the command is done.
// Reset (aresetn, synchronous, active low) clears all shadow rows, drops
// any frame in flight and returns the sequencer to idle.

module led_matrix_chain_driver_unit
    import lmcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [1:0]         s_block,
    input  logic [2:0]         s_row,
    input  logic [2:0]         s_column,
    input  logic               s_led_on,
    input  logic [7:0]         s_data,
    input  logic [3:0]         s_reg_addr,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FRAME_W-1:0] m_chain_word,
    output logic               m_last
);

    dp_ctl_t ctl;
    logic    out_free;

    // microcode sequencer
    lmcd_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_block    (s_block),
        .s_row      (s_row),
        .s_column   (s_column),
        .s_led_on   (s_led_on),
        .s_data     (s_data),
        .s_reg_addr (s_reg_addr),
        .out_free   (out_free),
        .ctl        (ctl)
    );

    // shadow store and frame output
    lmcd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_chain_word (m_chain_word),
        .m_last       (m_last)
    );

endmodule

>>> hw/rtl/lmcd_checker.sv
// port-level checker for the led matrix chain driver, with its bind
`timescale 1ns / 1ps

module lmcd_checker
    import lmcd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FRAME_W-1:0] m_chain_word,
    input logic               m_last
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_chain_word)
            && $stable(m_last))
        else $error("output beat changed while stalled");

    // a command beat makes the block busy
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready |=> !s_ready)
        else $error("input taken while a command is in work");

    // only one block slot of a frame carries a command
    a_one_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({|m_chain_word[63:48], |m_chain_word[47:32],
            |m_chain_word[31:16], |m_chain_word[15:0]}) <= 1)
        else $error("frame addresses more than one block");

    // reset empties the output
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind led_matrix_chain_driver_unit lmcd_checker u_lmcd_checker (.*);
